// File: hw/rtl/shat_pkg.sv
// ----------------------------------------------------------------------------
// shat_pkg
// shared types and constants of the speed-hold autothrottle
// ----------------------------------------------------------------------------
package shat_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_MIN_SPEED    = 2'd0;
    localparam logic [1:0] REG_MAX_SPEED    = 2'd1;
    localparam logic [1:0] REG_BURNER_DELTA = 2'd2;

    // configuration reset values, 1/16 kt
    localparam logic [13:0] MIN_SPEED_RST    = 14'd3200;
    localparam logic [13:0] MAX_SPEED_RST    = 14'd12800;
    localparam logic [13:0] BURNER_DELTA_RST = 14'd11200;

    // speed limits and error thresholds, 1/16 kt
    localparam logic signed [15:0] TGT_MARGIN  = 16'sd320;
    localparam logic signed [15:0] OVER_BIAS   = 16'sd640;
    localparam logic signed [15:0] IDLE_ERR    = -16'sd800;
    localparam logic signed [15:0] PROP_OFFSET = 16'sd1600;

    // acceleration clip, 1/256 ft/s^2
    localparam logic signed [15:0] ACCEL_CLIP    = 16'sd1280;
    localparam logic signed [11:0] ACCEL_CLIP_12 = 12'sd1280;

    // reciprocals, exact over the operand ranges used
    localparam logic [19:0] PROP_RECIP  = 20'd536871;     // ceil(2^26 / 125)
    localparam int          PROP_SHIFT  = 26;
    localparam logic [16:0] PITCH_RECIP = 17'd69906;      // ceil(2^20 / 15)
    localparam int          PITCH_SHIFT = 20;
    localparam logic [31:0] STEP_RECIP  = 32'd2199023256; // ceil(2^38 / 125)
    localparam int          STEP_SHIFT  = 38;

    // throttle and integrator limits
    localparam logic signed [18:0] THR_FULL  = 19'sd24576; // 1.5 in Q14
    localparam logic signed [18:0] THR_CAP   = 19'sd16220; // 0.99 in Q14
    localparam logic [14:0]        THR_TRACK_MAX = 15'd18404; // cap plus largest stick term
    localparam logic [14:0]        THR_FULL_U    = 15'd24576;
    localparam logic signed [27:0] INTEG_LIM = 28'sd25165824; // 1.5 in Q24

    typedef enum logic [1:0] {
        LAW_IDLE   = 2'd0,
        LAW_BURNER = 2'd1,
        LAW_TRACK  = 2'd2
    } law_t;

    // after target clamp and error
    typedef struct packed {
        law_t               mode;
        logic signed [15:0] err;
        logic signed [15:0] tgt;
        logic               p_neg;
        logic [18:0]        p_mag;
        logic [15:0]        stick_mag;
        logic [15:0]        dt;
    } front_t;

    // after the first multiplies
    typedef struct packed {
        law_t        mode;
        logic        err_pos;
        logic        err_neg;
        logic [17:0] prop;
        logic        p_neg;
        logic [34:0] prod;
        logic [11:0] pitch_add;
        logic        on_speed;
    } scale_t;

    // integrator step ready
    typedef struct packed {
        law_t        mode;
        logic        err_pos;
        logic        err_neg;
        logic [17:0] prop;
        logic        p_neg;
        logic [25:0] step_mag;
        logic [11:0] pitch_add;
        logic        on_speed;
    } step_t;

endpackage

// File: hw/rtl/speed_hold_autothrottle_unit.sv
// ----------------------------------------------------------------------------
// speed_hold_autothrottle_unit
// speed-hold autothrottle law, one control tick per request
// ----------------------------------------------------------------------------
// Takes one control tick per request and returns one throttle command with
// an on-speed flag. A new request is taken every clock cycle while the
// result side does not stall; each request passes through the input register,
// clamp/error stage, two multiply stages and the result register. The
// integrator closes in the last stage, so ticks that follow each other
// directly see each other's integrator update. While a result waits,
// requests keep flowing into the empty stages. Configuration writes take
// effect at once and belong between bursts of requests, with the pipeline
// drained.
// ----------------------------------------------------------------------------
module speed_hold_autothrottle_unit (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [13:0]        cfg_data,
    // tick requests
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [13:0]        target_speed,
    input  logic [13:0]        current_speed,
    input  logic signed [15:0] accel,
    input  logic signed [15:0] pitch_stick,
    input  logic               add_pitch,
    input  logic [15:0]        tick_len,
    // throttle results
    output logic               out_valid,
    input  logic               out_ready,
    output logic [14:0]        throttle,
    output logic               on_speed
);
    import shat_pkg::*;

    // configuration registers, 1/16 kt
    logic [13:0] min_speed_reg;
    logic [13:0] max_speed_reg;
    logic [13:0] burner_delta_reg;

    // stage links
    logic   s1_valid;
    logic   s1_ready;
    front_t s1_data;
    logic   s3_valid;
    logic   s3_ready;
    step_t  s3_data;

    // writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_speed_reg    <= MIN_SPEED_RST;
            max_speed_reg    <= MAX_SPEED_RST;
            burner_delta_reg <= BURNER_DELTA_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MIN_SPEED:    min_speed_reg    <= cfg_data;
                REG_MAX_SPEED:    max_speed_reg    <= cfg_data;
                REG_BURNER_DELTA: burner_delta_reg <= cfg_data;
                default:          ; // unused index, write dropped
            endcase
        end
    end

    // input register, target clamp, error and law choice
    shat_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .target_speed  (target_speed),
        .current_speed (current_speed),
        .accel         (accel),
        .pitch_stick   (pitch_stick),
        .add_pitch     (add_pitch),
        .tick_len      (tick_len),
        .min_speed     (min_speed_reg),
        .max_speed     (max_speed_reg),
        .burner_delta  (burner_delta_reg),
        .s1_valid      (s1_valid),
        .s1_ready      (s1_ready),
        .s1_data       (s1_data)
    );

    // proportional term, stick term and integrator step by reciprocal multiply
    shat_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1_data  (s1_data),
        .s3_valid (s3_valid),
        .s3_ready (s3_ready),
        .s3_data  (s3_data)
    );

    // integrator, throttle limits and result register
    shat_law u_law (
        .clk       (clk),
        .rst_n     (rst_n),
        .s3_valid  (s3_valid),
        .s3_ready  (s3_ready),
        .s3_data   (s3_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .throttle  (throttle),
        .on_speed  (on_speed)
    );

endmodule

// File: hw/rtl/shat_front.sv
// ----------------------------------------------------------------------------
// shat_front
// input register, target clamp, speed error and law selection
// ----------------------------------------------------------------------------
module shat_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [13:0]           target_speed,
    input  logic [13:0]           current_speed,
    input  logic signed [15:0]    accel,
    input  logic signed [15:0]    pitch_stick,
    input  logic                  add_pitch,
    input  logic [15:0]           tick_len,
    input  logic [13:0]           min_speed,
    input  logic [13:0]           max_speed,
    input  logic [13:0]           burner_delta,
    output logic                  s1_valid,
    input  logic                  s1_ready,
    output shat_pkg::front_t      s1_data
);
    import shat_pkg::*;

    typedef struct packed {
        logic [13:0]        target_speed;
        logic [13:0]        current_speed;
        logic signed [15:0] accel;
        logic signed [15:0] pitch_stick;
        logic               add_pitch;
        logic [15:0]        tick_len;
    } tick_t;

    logic   in_valid_reg;
    tick_t  raw_reg;
    logic   s1_valid_reg;
    front_t s1_reg;
    front_t s1_next;
    logic   rdy1;

    logic signed [15:0] min_s;
    logic signed [15:0] hi_s;
    logic signed [15:0] tgt_in_s;
    logic signed [15:0] tgt_lo_s;
    logic signed [15:0] cur_s;
    logic signed [15:0] bdelta_s;
    logic signed [15:0] err_s;
    logic signed [15:0] tgt_s;
    logic               over;
    logic signed [11:0] acc_c;
    logic signed [20:0] err_w;
    logic signed [20:0] acc_w;
    logic signed [20:0] p_s;
    logic [20:0]        p_abs;
    logic [15:0]        stick_u;
    logic [15:0]        stick_abs;
    law_t               mode;

    assign rdy1     = !s1_valid_reg || s1_ready;
    assign in_ready = !in_valid_reg || rdy1;
    assign s1_valid = s1_valid_reg;
    assign s1_data  = s1_reg;

    always_comb
    begin
        min_s    = signed'({2'b00, min_speed});
        hi_s     = signed'({2'b00, max_speed}) - TGT_MARGIN;
        tgt_in_s = signed'({2'b00, raw_reg.target_speed});
        cur_s    = signed'({2'b00, raw_reg.current_speed});
        bdelta_s = signed'({2'b00, burner_delta});
        tgt_lo_s = (raw_reg.target_speed < min_speed) ? min_s : tgt_in_s;
        // upper clamp applied second, so it wins on inverted limits
        over     = tgt_lo_s > hi_s;
        tgt_s    = over ? hi_s : tgt_lo_s;
        err_s    = over ? (hi_s - cur_s - OVER_BIAS) : (tgt_lo_s - cur_s);
    end

    always_comb
    begin
        priority if (err_s < IDLE_ERR)
            mode = LAW_IDLE;
        else if (err_s >= bdelta_s)
            mode = LAW_BURNER;
        else
            mode = LAW_TRACK;
    end

    always_comb
    begin
        priority if (raw_reg.accel > ACCEL_CLIP)
            acc_c = ACCEL_CLIP_12;
        else if (raw_reg.accel < -ACCEL_CLIP)
            acc_c = -ACCEL_CLIP_12;
        else
            acc_c = signed'(raw_reg.accel[11:0]);
    end

    // 16*err - 5*a, magnitude fits 19 bits whenever the tracking law runs
    always_comb
    begin
        err_w = {{5{err_s[15]}}, err_s};
        acc_w = {{9{acc_c[11]}}, acc_c};
        p_s   = (err_w <<< 4) - (acc_w <<< 2) - acc_w;
        p_abs = p_s[20] ? unsigned'(-p_s) : unsigned'(p_s);
    end

    always_comb
    begin
        stick_u   = unsigned'(raw_reg.pitch_stick);
        stick_abs = stick_u[15] ? (~stick_u + 16'd1) : stick_u;
    end

    always_comb
    begin
        s1_next.mode      = mode;
        s1_next.err       = err_s;
        s1_next.tgt       = tgt_s;
        s1_next.p_neg     = p_s[20];
        s1_next.p_mag     = p_abs[18:0];
        s1_next.stick_mag = raw_reg.add_pitch ? stick_abs : 16'd0;
        s1_next.dt        = raw_reg.tick_len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (rdy1)
                s1_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            raw_reg.target_speed  <= target_speed;
            raw_reg.current_speed <= current_speed;
            raw_reg.accel         <= accel;
            raw_reg.pitch_stick   <= pitch_stick;
            raw_reg.add_pitch     <= add_pitch;
            raw_reg.tick_len      <= tick_len;
        end
        if (rdy1 && in_valid_reg)
            s1_reg <= s1_next;
    end

endmodule

// File: hw/rtl/shat_scale.sv
// ----------------------------------------------------------------------------
// shat_scale
// proportional term, integrator step and stick term, two multiply stages
// ----------------------------------------------------------------------------
module shat_scale (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s1_valid,
    output logic             s1_ready,
    input  shat_pkg::front_t s1_data,
    output logic             s3_valid,
    input  logic             s3_ready,
    output shat_pkg::step_t  s3_data
);
    import shat_pkg::*;

    logic   s2_valid_reg;
    scale_t s2_reg;
    scale_t s2_next;
    logic   s3_valid_reg;
    step_t  s3_reg;
    step_t  s3_next;
    logic   rdy2;
    logic   rdy3;

    logic signed [15:0] v_sum;
    logic [14:0]        v;
    logic [19:0]        x;
    logic [39:0]        pq;
    logic [17:0]        prop;
    logic [32:0]        pp;
    logic [15:0]        aerr;
    logic [17:0]        ten_aerr;
    logic [31:0]        y;
    logic [63:0]        qq;

    assign rdy3     = !s3_valid_reg || s3_ready;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign s1_ready = rdy2;
    assign s3_valid = s3_valid_reg;
    assign s3_data  = s3_reg;

    // (err + 1600) * 1024 / 125 = 8v + floor(24v / 125)
    always_comb
    begin
        v_sum = s1_data.err + PROP_OFFSET;
        v     = unsigned'(v_sum[14:0]);
        x     = {1'b0, v, 4'b0000} + {2'b00, v, 3'b000};
        pq    = 40'(x) * 40'(PROP_RECIP);
        prop  = {v, 3'b000} + {6'd0, pq[PROP_SHIFT+11:PROP_SHIFT]};
    end

    // |stick| / 15
    always_comb
    begin
        pp = 33'(s1_data.stick_mag) * 33'(PITCH_RECIP);
    end

    // on-speed: 10*|err| below the clamped target
    always_comb
    begin
        aerr     = s1_data.err[15] ? unsigned'(-s1_data.err) : unsigned'(s1_data.err);
        ten_aerr = {aerr[14:0], 3'b000} + {2'b00, aerr[14:0], 1'b0};
    end

    always_comb
    begin
        s2_next.mode      = s1_data.mode;
        s2_next.err_pos   = !s1_data.err[15] && (s1_data.err != 16'sd0);
        s2_next.err_neg   = s1_data.err[15];
        s2_next.prop      = prop;
        s2_next.p_neg     = s1_data.p_neg;
        s2_next.prod      = 35'(s1_data.p_mag) * 35'(s1_data.dt);
        s2_next.pitch_add = pp[PITCH_SHIFT+11:PITCH_SHIFT];
        s2_next.on_speed  = !s1_data.tgt[15] && (ten_aerr < {3'b000, s1_data.tgt[14:0]});
    end

    // truncated |prod| / 1000 as (|prod| >> 3) / 125
    always_comb
    begin
        y  = s2_reg.prod[34:3];
        qq = 64'(y) * 64'(STEP_RECIP);
    end

    always_comb
    begin
        s3_next.mode      = s2_reg.mode;
        s3_next.err_pos   = s2_reg.err_pos;
        s3_next.err_neg   = s2_reg.err_neg;
        s3_next.prop      = s2_reg.prop;
        s3_next.p_neg     = s2_reg.p_neg;
        s3_next.step_mag  = qq[STEP_SHIFT+25:STEP_SHIFT];
        s3_next.pitch_add = s2_reg.pitch_add;
        s3_next.on_speed  = s2_reg.on_speed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy2)
                s2_valid_reg <= s1_valid;
            if (rdy3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && s1_valid)
            s2_reg <= s2_next;
        if (rdy3 && s2_valid_reg)
            s3_reg <= s3_next;
    end

endmodule

// File: hw/rtl/shat_law.sv
// ----------------------------------------------------------------------------
// shat_law
// integrator update, throttle law and result register
// ----------------------------------------------------------------------------
module shat_law (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s3_valid,
    output logic            s3_ready,
    input  shat_pkg::step_t s3_data,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [14:0]     throttle,
    output logic            on_speed
);
    import shat_pkg::*;

    logic               out_valid_reg;
    logic [14:0]        throttle_reg;
    logic [14:0]        throttle_next;
    logic               on_speed_reg;
    logic signed [25:0] integral_reg;
    logic signed [25:0] integral_next;
    logic               rdy_out;
    logic               fire;

    logic signed [27:0] mag_s;
    logic signed [27:0] step_s;
    logic signed [27:0] sum_s;
    logic signed [27:0] integ_c;
    logic signed [15:0] integ_q14;
    logic signed [18:0] thr_track;
    logic signed [18:0] thr_base;
    logic signed [18:0] thr_sum;

    assign rdy_out   = !out_valid_reg || out_ready;
    assign s3_ready  = rdy_out;
    assign fire      = s3_valid && rdy_out;
    assign out_valid = out_valid_reg;
    assign throttle  = throttle_reg;
    assign on_speed  = on_speed_reg;

    always_comb
    begin
        mag_s  = signed'({2'b00, s3_data.step_mag});
        step_s = s3_data.p_neg ? -mag_s : mag_s;
        sum_s  = {{2{integral_reg[25]}}, integral_reg} + step_s;
        // sign disagreement with the error zeroes the integrator
        priority if (s3_data.err_pos && sum_s < 28'sd0)
            integ_c = 28'sd0;
        else if (s3_data.err_neg && sum_s > 28'sd0)
            integ_c = 28'sd0;
        else if (sum_s > INTEG_LIM)
            integ_c = INTEG_LIM;
        else if (sum_s < -INTEG_LIM)
            integ_c = -INTEG_LIM;
        else
            integ_c = sum_s;
        integral_next = integ_c[25:0];
    end

    always_comb
    begin
        integ_q14 = integ_c[25:10];
        thr_track = signed'({1'b0, s3_data.prop}) + {{3{integ_q14[15]}}, integ_q14};
        if (thr_track > THR_CAP)
            thr_track = THR_CAP;
        unique case (s3_data.mode)
            LAW_IDLE:   thr_base = 19'sd0;
            LAW_BURNER: thr_base = THR_FULL;
            LAW_TRACK:  thr_base = thr_track;
            default:    thr_base = 19'sd0;
        endcase
        thr_sum = thr_base + signed'({7'd0, s3_data.pitch_add});
        priority if (thr_sum > THR_FULL)
            throttle_next = THR_FULL_U;
        else if (thr_sum < 19'sd0)
            throttle_next = 15'd0;
        else
            throttle_next = unsigned'(thr_sum[14:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            integral_reg  <= 26'sd0;
        end
        else
        begin
            if (rdy_out)
                out_valid_reg <= s3_valid;
            if (fire && s3_data.mode == LAW_TRACK)
                integral_reg <= integral_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            throttle_reg <= throttle_next;
            on_speed_reg <= s3_data.on_speed;
        end
    end

endmodule

// File: hw/rtl/shat_checker.sv
// ----------------------------------------------------------------------------
// shat_checker
// port-level checks of the speed-hold autothrottle, bound to the top level
// ----------------------------------------------------------------------------
module shat_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [14:0] throttle,
    input logic        on_speed
);
    import shat_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(throttle) && $stable(on_speed))
        else $error("result changed while stalled");

    // throttle never beyond full burner
    a_thr_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> throttle <= THR_FULL_U)
        else $error("throttle above full burner");

    // only full burner lies above the capped law plus stick term
    a_thr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (throttle <= THR_TRACK_MAX || throttle == THR_FULL_U))
        else $error("throttle between cap and full burner");

    // an empty result register never holds off requests
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request refused with empty result register");

endmodule

bind speed_hold_autothrottle_unit shat_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .throttle  (throttle),
    .on_speed  (on_speed)
);

// File: tb/tb_speed_hold_autothrottle_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_speed_hold_autothrottle_unit
// self-checking bench for the speed-hold autothrottle law
// ----------------------------------------------------------------------------
// Drives control ticks through the request channel and compares every
// throttle result with a cycle-free predictor of the law, integrator
// included. A short table of hand-picked ticks comes first, then shaped
// random runs under a range of limit settings, with three mixes of sender
// gaps and receiver stalls. Registers are only rewritten with the pipe empty.
// ----------------------------------------------------------------------------
module tb_speed_hold_autothrottle_unit;

    import shat_pkg::*;

    // ------------------------------------------------------------------------
    // bench constants
    // ------------------------------------------------------------------------
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_GAP    = 8;      // pipe holds five requests, allow a margin
    localparam int DIR_ROWS     = 22;
    localparam int SEGMENTS     = 12;
    localparam int SEG_TICKS    = 58;

    // law constants in 1/16 kt, Q14 and Q24
    localparam longint TARGET_MARGIN  = 320;
    localparam longint OVERSPEED_BIAS = 640;
    localparam longint IDLE_LIMIT     = -800;
    localparam longint PROP_BIAS      = 1600;
    localparam longint ACC_LIMIT      = 1280;
    localparam longint FULL_BURNER    = 24576;
    localparam longint TRACK_CAP      = 16220;
    localparam longint INTEG_LIMIT    = 25165824;

    // kinds of random run
    localparam int RUN_UNDER = 0;     // below target, positive error
    localparam int RUN_OVER  = 1;     // above target, negative error
    localparam int RUN_NEAR  = 2;     // error of either sign near zero
    localparam int RUN_NOISE = 3;     // every field random

    typedef struct {
        logic [13:0]        tgt;
        logic [13:0]        cur;
        logic signed [15:0] accel;
        logic signed [15:0] stick;
        logic               addp;
        logic [15:0]        dt;
    } tick_t;

    typedef struct {
        int          seq;
        logic [14:0] thr;
        logic        on_spd;
    } throttle_res_t;

    typedef struct {
        tick_t       tick;
        bit          has_exp;
        logic [14:0] thr;
        logic        on_spd;
    } dir_row_t;

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [13:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [13:0]        target_speed;
    logic [13:0]        current_speed;
    logic signed [15:0] accel;
    logic signed [15:0] pitch_stick;
    logic               add_pitch;
    logic [15:0]        tick_len;
    logic               out_valid;
    logic               out_ready;
    logic [14:0]        throttle;
    logic               on_speed;

    // predictor copy of the registers and of the integrator
    logic [13:0]        min_speed_r;
    logic [13:0]        max_speed_r;
    logic [13:0]        burner_delta_r;
    logic signed [25:0] integ_q24;

    // throttle results still owed by the block, oldest first
    throttle_res_t      pending_throttle_q[$];
    throttle_res_t      head;

    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 send_burst_left;
    int                 recv_burst_left;
    int                 n_sent;
    int                 n_checked;
    int                 n_fail;
    int                 n_settings;
    int                 cycle_count;

    speed_hold_autothrottle_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .target_speed  (target_speed),
        .current_speed (current_speed),
        .accel         (accel),
        .pitch_stick   (pitch_stick),
        .add_pitch     (add_pitch),
        .tick_len      (tick_len),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .throttle      (throttle),
        .on_speed      (on_speed)
    );

    // ------------------------------------------------------------------------
    // directed ticks, reset limits in force (min 200 kt, cap 780 kt, burner
    // 700 kt); expected values typed in where the law is obvious
    // ------------------------------------------------------------------------
    dir_row_t dir_tab [0:DIR_ROWS-1] = '{
        // target raised to minimum, far too fast: idle, not on speed
        '{'{14'd0,     14'd16383, 16'sd0,      16'sd0,      1'b0, 16'd0},
          1'b1, 15'd0,     1'b0},
        // target above cap gets cut and biased, error past burner threshold
        '{'{14'd16383, 14'd0,     16'sd0,      16'sd0,      1'b0, 16'd0},
          1'b1, 15'd24576, 1'b0},
        // burner plus stick term still clamps at 1.5
        '{'{14'd16383, 14'd0,     16'sd0,     -16'sd16384,  1'b1, 16'd0},
          1'b1, 15'd24576, 1'b0},
        // idle plus full stick
        '{'{14'd0,     14'd16383, 16'sd0,      16'sd16384,  1'b1, 16'd0},
          1'b1, 15'd1092,  1'b0},
        // stick beyond nominal range, most negative code
        '{'{14'd0,     14'd16383, 16'sd0,     -16'sd32768,  1'b1, 16'd0},
          1'b1, 15'd2184,  1'b0},
        '{'{14'd0,     14'd16383, 16'sd0,      16'sd32767,  1'b1, 16'd0},
          1'b1, 15'd2184,  1'b0},
        // zero error, no time step: proportional term only
        '{'{14'd8000,  14'd8000,  16'sd0,      16'sd0,      1'b0, 16'd0},
          1'b1, 15'd13107, 1'b1},
        // on-speed edge, just inside and just outside, accel clipped
        '{'{14'd8000,  14'd7201,  16'sd32767,  16'sd0,      1'b0, 16'd65535},
          1'b0, 15'd0,     1'b0},
        '{'{14'd8000,  14'd7200, -16'sd32768,  16'sd0,      1'b0, 16'd65535},
          1'b0, 15'd0,     1'b0},
        // idle edge: still tracking, integral of the other sign is dropped
        '{'{14'd8000,  14'd8800,  16'sd0,      16'sd0,      1'b0, 16'd65535},
          1'b0, 15'd0,     1'b0},
        // one past the idle edge, integrator held
        '{'{14'd8000,  14'd8801,  16'sd0,      16'sd0,      1'b0, 16'd65535},
          1'b0, 15'd0,     1'b0},
        '{'{14'd8000,  14'd8500, -16'sd1280,   16'sd0,      1'b0, 16'd65535},
          1'b0, 15'd0,     1'b0},
        // positive error against a negative integral
        '{'{14'd8000,  14'd7800,  16'sd0,      16'sd0,      1'b0, 16'd30000},
          1'b0, 15'd0,     1'b0},
        // error exactly at the burner threshold, target exactly at the cap
        '{'{14'd12480, 14'd1280,  16'sd0,      16'sd0,      1'b0, 16'd0},
          1'b1, 15'd24576, 1'b0},
        // one below the threshold: tracking, held at the 0.99 cap
        '{'{14'd12480, 14'd1281,  16'sd0,      16'sd0,      1'b0, 16'd0},
          1'b1, 15'd16220, 1'b0},
        // one above the cap: target cut, overspeed bias applies
        '{'{14'd12481, 14'd12000, 16'sd100,    16'sd0,      1'b0, 16'd20000},
          1'b0, 15'd0,     1'b0},
        '{'{14'd16383, 14'd11000, 16'sd0,      16'sd0,      1'b0, 16'd65535},
          1'b0, 15'd0,     1'b0},
        // one below the minimum, raised onto current speed
        '{'{14'd3199,  14'd3200,  16'sd0,      16'sd0,      1'b0, 16'd1000},
          1'b0, 15'd0,     1'b0},
        // accel one past the clip either side
        '{'{14'd6000,  14'd6100,  16'sd1281,   16'sd0,      1'b0, 16'd40000},
          1'b0, 15'd0,     1'b0},
        '{'{14'd6000,  14'd6100, -16'sd1281,   16'sd0,      1'b0, 16'd40000},
          1'b0, 15'd0,     1'b0},
        // tracking plus stick term
        '{'{14'd12000, 14'd11000, 16'sd0,      16'sd16384,  1'b1, 16'd65535},
          1'b0, 15'd0,     1'b0},
        // all ones where the fields allow: idle, stick term rounds to zero
        '{'{14'd16383, 14'd16383, -16'sd1,    -16'sd1,      1'b1, 16'd65535},
          1'b1, 15'd0,     1'b0}
    };

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // predictor: one tick of the law, updates the integrator copy
    // ------------------------------------------------------------------------
    function automatic throttle_res_t predict_throttle(input tick_t t);
        throttle_res_t r;
        longint        tgt;
        longint        cur;
        longint        hi;
        longint        err;
        longint        acc;
        longint        thr;
        longint        integ;
        longint        mag;
        longint        aerr;
        tgt = longint'(t.tgt);
        cur = longint'(t.cur);
        hi  = longint'(max_speed_r) - TARGET_MARGIN;
        err = tgt - cur;
        // minimum first, then the cap, so the cap wins on inverted limits
        if (tgt < longint'(min_speed_r))
        begin
            tgt = longint'(min_speed_r);
            err = tgt - cur;
        end
        if (tgt > hi)
        begin
            tgt = hi;
            err = tgt - cur - OVERSPEED_BIAS;
        end
        if (err < IDLE_LIMIT)
            thr = 0;
        else if (err >= longint'(burner_delta_r))
            thr = FULL_BURNER;
        else
        begin
            acc = longint'(t.accel);
            if (acc > ACC_LIMIT)
                acc = ACC_LIMIT;
            else if (acc < -ACC_LIMIT)
                acc = -ACC_LIMIT;
            thr   = ((err + PROP_BIAS) * 1024) / 125;
            integ = longint'(integ_q24) + ((16 * err - 5 * acc) * longint'(t.dt)) / 1000;
            // drop the integral when it disagrees in sign with the error
            if (err > 0 && integ < 0)
                integ = 0;
            else if (err < 0 && integ > 0)
                integ = 0;
            if (integ > INTEG_LIMIT)
                integ = INTEG_LIMIT;
            else if (integ < -INTEG_LIMIT)
                integ = -INTEG_LIMIT;
            integ_q24 = integ[25:0];
            thr = thr + (integ >>> 10);
            if (thr > TRACK_CAP)
                thr = TRACK_CAP;
        end
        if (t.addp)
        begin
            mag = longint'(t.stick);
            if (mag < 0)
                mag = -mag;
            thr = thr + mag / 15;
        end
        if (thr > FULL_BURNER)
            thr = FULL_BURNER;
        if (thr < 0)
            thr = 0;
        aerr = (err < 0) ? -err : err;
        r.seq    = n_sent;
        r.thr    = thr[14:0];
        r.on_spd = (10 * aerr < tgt);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // shaped random tick around the current limits
    // ------------------------------------------------------------------------
    function automatic tick_t make_tick(input int kind);
        tick_t t;
        int    lo;
        int    top;
        int    tg;
        int    e;
        int    c;
        if (kind == RUN_NOISE)
        begin
            t.tgt   = 14'($urandom);
            t.cur   = 14'($urandom);
            t.accel = 16'($urandom);
            t.stick = 16'($urandom);
            t.addp  = 1'($urandom);
            t.dt    = 16'($urandom);
            return t;
        end
        lo  = int'(min_speed_r);
        top = int'(max_speed_r) - 320;
        // mostly inside the allowed band, now and then anywhere
        if (top >= lo && $urandom_range(9) != 0)
            tg = $urandom_range(top, lo);
        else
            tg = $urandom_range(16383);
        case (kind)
            RUN_UNDER: e = $urandom_range(1200, 1);
            RUN_OVER:  e = -int'($urandom_range(800, 1));
            default:   e = int'($urandom_range(2400)) - 1200;
        endcase
        c = tg - e;
        if (c < 0)
            c = 0;
        if (c > 16383)
            c = 16383;
        t.tgt = tg[13:0];
        t.cur = c[13:0];
        if ($urandom_range(9) == 0)
            t.accel = 16'($urandom);
        else
            t.accel = 16'(int'($urandom_range(3000)) - 1500);
        if ($urandom_range(9) == 0)
            t.stick = 16'($urandom);
        else
            t.stick = 16'(int'($urandom_range(32768)) - 16384);
        case ($urandom_range(3))
            0:       t.dt = 16'($urandom_range(2000));
            1:       t.dt = 16'($urandom_range(65535, 60000));
            default: t.dt = 16'($urandom_range(65535));
        endcase
        t.addp = 1'($urandom_range(1));
        return t;
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    // one tick request; called at a falling edge, returns at a falling edge
    task automatic send_tick(input tick_t t, input bit has_exp,
                             input logic [14:0] exp_thr, input logic exp_on);
        throttle_res_t r;
        // random gaps, except inside a burst
        if (send_burst_left > 0)
            send_burst_left--;
        else
        begin
            if ($urandom_range(99) < 4)
                send_burst_left = $urandom_range(40, 10);
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        end
        target_speed  = t.tgt;
        current_speed = t.cur;
        accel         = t.accel;
        pitch_stick   = t.stick;
        add_pitch     = t.addp;
        tick_len      = t.dt;
        in_valid      = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        // accepted: predict in acceptance order
        r = predict_throttle(t);
        if (has_exp)
        begin
            r.thr    = exp_thr;
            r.on_spd = exp_on;
        end
        pending_throttle_q.push_back(r);
        n_sent++;
        @(negedge clk);
    endtask

    // hold requests back until every owed throttle result is in
    task automatic wait_drained();
        while (pending_throttle_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
        @(negedge clk);
    endtask

    // one register write; called at a falling edge, returns at one
    task automatic write_reg(input logic [1:0] idx, input logic [13:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_MIN_SPEED:    min_speed_r    = val;
            REG_MAX_SPEED:    max_speed_r    = val;
            REG_BURNER_DELTA: burner_delta_r = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls with occasional stall-free stretches
    // ------------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (recv_burst_left > 0)
            begin
                recv_burst_left--;
                out_ready = 1'b1;
            end
            else
            begin
                if ($urandom_range(99) < 3)
                    recv_burst_left = $urandom_range(40, 10);
                out_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker, oldest expectation first
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_throttle_q.size() == 0)
            begin
                n_fail++;
                $display("%0t throttle result with none owed: thr=%0d on_speed=%0b",
                         $time, throttle, on_speed);
            end
            else
            begin
                head = pending_throttle_q.pop_front();
                n_checked++;
                if (throttle !== head.thr)
                begin
                    n_fail++;
                    $display("%0t tick %0d throttle: expected %0d, got %0d",
                             $time, head.seq, head.thr, throttle);
                end
                if (on_speed !== head.on_spd)
                begin
                    n_fail++;
                    $display("%0t tick %0d on_speed: expected %0b, got %0b",
                             $time, head.seq, head.on_spd, on_speed);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t watchdog expired, %0d results still owed",
                     $time, pending_throttle_q.size());
            $display("tb_speed_hold_autothrottle_unit NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [13:0] set_min;
        logic [13:0] set_max;
        logic [13:0] set_burn;
        int          run_kind;
        int          run_left;
        int          pick;

        // every input known from time zero
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = REG_MIN_SPEED;
        cfg_data        = '0;
        in_valid        = 1'b0;
        target_speed    = '0;
        current_speed   = '0;
        accel           = '0;
        pitch_stick     = '0;
        add_pitch       = 1'b0;
        tick_len        = '0;
        send_idle_pct   = 32;
        recv_stall_pct  = 81;
        send_burst_left = 0;
        recv_burst_left = 0;
        n_sent          = 0;
        n_checked       = 0;
        n_fail          = 0;
        n_settings      = 1;
        cycle_count     = 0;
        run_kind        = RUN_NEAR;
        run_left        = 0;

        // predictor copy starts at the reset values
        min_speed_r    = MIN_SPEED_RST;
        max_speed_r    = MAX_SPEED_RST;
        burner_delta_r = BURNER_DELTA_RST;
        integ_q24      = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table, reset limits
        for (int i = 0; i < DIR_ROWS; i++)
            send_tick(dir_tab[i].tick, dir_tab[i].has_exp, dir_tab[i].thr,
                      dir_tab[i].on_spd);

        // random segments: four per handshake mix, new limits for each but the first
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg / 4)
                0:
                begin
                    send_idle_pct  = 32;
                    recv_stall_pct = 81;
                end
                1:
                begin
                    send_idle_pct  = 81;
                    recv_stall_pct = 32;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase

            if (seg != 0)
            begin
                case (seg)
                    1:
                    begin
                        // widest band, burner on any non-negative error
                        set_min  = 14'd0;
                        set_max  = 14'd16383;
                        set_burn = 14'd0;
                    end
                    2:
                    begin
                        // inverted limits with a negative target: all idle
                        set_min  = 14'd16383;
                        set_max  = 14'd0;
                        set_burn = 14'd16383;
                    end
                    3:
                    begin
                        set_min  = 14'd4000;
                        set_max  = 14'd12000;
                        set_burn = 14'd16383;
                    end
                    4:
                    begin
                        // inverted, cap wins over the minimum
                        set_min  = 14'd16383;
                        set_max  = 14'd16383;
                        set_burn = 14'd800;
                    end
                    5:
                    begin
                        // cap just below the margin, target goes negative
                        set_min  = 14'($urandom_range(6000));
                        set_max  = 14'd200;
                        set_burn = 14'($urandom_range(16383));
                    end
                    SEGMENTS - 1:
                    begin
                        set_min  = MIN_SPEED_RST;
                        set_max  = MAX_SPEED_RST;
                        set_burn = BURNER_DELTA_RST;
                    end
                    default:
                    begin
                        set_min  = 14'($urandom_range(6000));
                        set_max  = 14'($urandom_range(16383, 8000));
                        set_burn = 14'($urandom_range(16383, 200));
                    end
                endcase
                // limits only change with the pipe empty
                in_valid = 1'b0;
                wait_drained();
                write_reg(REG_MIN_SPEED, set_min);
                write_reg(REG_MAX_SPEED, set_max);
                write_reg(REG_BURNER_DELTA, set_burn);
                n_settings++;
            end

            for (int k = 0; k < SEG_TICKS; k++)
            begin
                // runs of one kind so the integrator can wind up and saturate
                if (run_left == 0)
                begin
                    pick = $urandom_range(99);
                    if (pick < 35)
                        run_kind = RUN_UNDER;
                    else if (pick < 60)
                        run_kind = RUN_OVER;
                    else if (pick < 85)
                        run_kind = RUN_NEAR;
                    else
                        run_kind = RUN_NOISE;
                    run_left = $urandom_range(30, 10);
                end
                run_left--;
                send_tick(make_tick(run_kind), 1'b0, '0, 1'b0);
            end
        end

        // all requests in; let the last results come back
        in_valid = 1'b0;
        while (pending_throttle_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);

        $display("run covered %0d ticks (%0d from the table) and %0d checked results",
                 n_sent, DIR_ROWS, n_checked);
        $display("across %0d limit settings and three gap/stall mixes, %0d mismatches",
                 n_settings, n_fail);
        if (n_fail == 0)
            $display("tb_speed_hold_autothrottle_unit OK");
        else
            $display("tb_speed_hold_autothrottle_unit NOT OK");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/shat_pkg.sv
hw/rtl/shat_front.sv
hw/rtl/shat_scale.sv
hw/rtl/shat_law.sv
hw/rtl/speed_hold_autothrottle_unit.sv
hw/rtl/shat_checker.sv
tb/tb_speed_hold_autothrottle_unit.sv
